// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// depends on nothing; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define C8X_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is active
`define C8X_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/c8x_pkg.sv =====
// shared types and constants of the chip8 execute unit
// depends on nothing
package c8x_pkg;

    localparam int          MEMORY_BYTES  = 4096;
    localparam int          ADDR_W        = 12;
    localparam int          STACK_DEPTH   = 16;
    localparam int          FRAME_ROWS    = 32;
    localparam int          NUM_REGS      = 16;
    localparam logic [11:0] PROGRAM_START = 12'h200;
    localparam logic [11:0] FONT_START    = 12'h050;
    localparam int          FONT_BYTES    = 80;
    localparam logic [7:0]  DELAY_RESET   = 8'd60;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_EXEC = 2'd1;
    localparam logic [1:0] MODE_ROW  = 2'd2;

    localparam logic [7:0] FONT_GLYPHS [0:FONT_BYTES-1] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] address;
        logic [7:0]  data_byte;
        logic [15:0] keys_down;
        logic [7:0]  random_byte;
    } t_in;

    typedef struct packed {
        logic        status;
        logic [11:0] program_counter;
        logic [15:0] executed_opcode;
        logic        display_changed;
        logic        sound_active;
        logic [63:0] row_pixels;
    } t_out;

endpackage

// ===== rtl/chip8_instruction_execute_unit.sv =====
// chip8 execute unit top level: sequencer around the memory, register,
// stack and frame rams; depends on c8x_pkg and c8x_ram
//
// One input beat is one step: mode 0 writes a memory byte, mode 2 reads a
// frame row, mode 1 fetches and executes one instruction, mode 3 only
// returns a result. Simple instructions go through two fetch reads, a
// register read, an execute step, a timer tick and the result load; 8XY4..8XY7
// and 8XYE add the flag write, DXYN adds one memory read and one frame
// read-modify-write per drawn sprite row, one more row check that ends the
// walk, then the flag write, FX33 adds three digit writes, FX55 and FX65 add
// a read and a write per byte since every ram read port is registered.
// After reset the unit clears program memory and lays in the hex font; no
// beat is accepted until that pass ends. Registers, the return stack and
// the frame buffer read as zero until written (00E0 clears the frame by
// dropping its row valid bits). A finished result sits in an output
// register, so the next beat is taken while it waits.
module chip8_instruction_execute_unit
    import c8x_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // sequencer states
    localparam logic [4:0] S_CLEAR   = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_MWR     = 5'd2;
    localparam logic [4:0] S_ROW_RD  = 5'd3;
    localparam logic [4:0] S_ROW_CAP = 5'd4;
    localparam logic [4:0] S_F0      = 5'd5;
    localparam logic [4:0] S_F1      = 5'd6;
    localparam logic [4:0] S_F2      = 5'd7;
    localparam logic [4:0] S_EX      = 5'd8;
    localparam logic [4:0] S_FLAG    = 5'd9;
    localparam logic [4:0] S_D_RD    = 5'd10;
    localparam logic [4:0] S_D_WR    = 5'd11;
    localparam logic [4:0] S_D_END   = 5'd12;
    localparam logic [4:0] S_BCD     = 5'd13;
    localparam logic [4:0] S_ST_RD   = 5'd14;
    localparam logic [4:0] S_ST_WR   = 5'd15;
    localparam logic [4:0] S_LD_RD   = 5'd16;
    localparam logic [4:0] S_LD_WR   = 5'd17;
    localparam logic [4:0] S_TICK    = 5'd18;
    localparam logic [4:0] S_DONE    = 5'd19;

    // opcode groups
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEI  = 4'h3;
    localparam logic [3:0] OP_SNEI = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LDI  = 4'h6;
    localparam logic [3:0] OP_ADDI = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDIX = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    localparam logic [15:0] W_CLS = 16'h00E0;
    localparam logic [15:0] W_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] K_SKP  = 8'h9E;
    localparam logic [7:0] K_SKNP = 8'hA1;
    localparam logic [7:0] F_GDT  = 8'h07;
    localparam logic [7:0] F_SDT  = 8'h15;
    localparam logic [7:0] F_SST  = 8'h18;
    localparam logic [7:0] F_ADI  = 8'h1E;
    localparam logic [7:0] F_FNT  = 8'h29;
    localparam logic [7:0] F_BCD  = 8'h33;
    localparam logic [7:0] F_STR  = 8'h55;
    localparam logic [7:0] F_LDR  = 8'h65;

    localparam logic [3:0] VF = 4'hF;

    // control and architectural state
    logic [4:0]  r_state, n_state;
    logic [11:0] r_clr;
    t_in         r_in;
    logic [15:0] r_op;
    logic [7:0]  r_vx, r_vy, r_flag;
    logic [11:0] r_pc, r_i;
    logic [3:0]  r_sp;
    logic [7:0]  r_dt, r_st;
    logic [4:0]  r_cnt;
    logic        r_hit, r_status, r_changed;
    logic [63:0] r_row;
    logic        r_out_valid;
    t_out        r_out;

    // valid bits: entries never written read as zero
    logic [NUM_REGS-1:0]    r_reg_ok;
    logic [STACK_DEPTH-1:0] r_stk_ok;
    logic [FRAME_ROWS-1:0]  r_frm_ok;
    logic                   r_reg_rok, r_stk_rok, r_frm_rok;

    // ram ports
    logic        mem_we;
    logic [11:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_rdata;
    logic        reg_we;
    logic [3:0]  reg_waddr, reg_raddr;
    logic [7:0]  reg_wdata, reg_rdata, reg_q;
    logic        stk_we;
    logic [3:0]  stk_waddr, stk_raddr;
    logic [11:0] stk_wdata, stk_rdata, stk_q;
    logic        frm_we;
    logic [4:0]  frm_waddr, frm_raddr;
    logic [63:0] frm_wdata, frm_rdata, frm_q;

    c8x_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_raddr(mem_raddr), .o_rdata(mem_rdata)
    );
    c8x_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_regs (
        .i_clk(i_clk), .i_we(reg_we), .i_waddr(reg_waddr), .i_wdata(reg_wdata),
        .i_raddr(reg_raddr), .o_rdata(reg_rdata)
    );
    c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );
    c8x_ram #(.WIDTH(64), .DEPTH(FRAME_ROWS)) u_frame (
        .i_clk(i_clk), .i_we(frm_we), .i_waddr(frm_waddr), .i_wdata(frm_wdata),
        .i_raddr(frm_raddr), .o_rdata(frm_rdata)
    );

    assign reg_q = r_reg_rok ? reg_rdata : 8'd0;
    assign stk_q = r_stk_rok ? stk_rdata : 12'd0;
    assign frm_q = r_frm_rok ? frm_rdata : 64'd0;

    // instruction fields
    logic [3:0]  op_x, op_n;
    logic [7:0]  op_nn;
    logic [11:0] op_nnn;
    assign op_x   = r_op[11:8];
    assign op_n   = r_op[3:0];
    assign op_nn  = r_op[7:0];
    assign op_nnn = r_op[11:0];

    // font fill during the clearing pass
    logic [11:0] font_off;
    logic [7:0]  font_byte;
    assign font_off  = r_clr - FONT_START;
    assign font_byte = (font_off < 12'(FONT_BYTES)) ? FONT_GLYPHS[font_off[6:0]] : 8'd0;

    // bcd digits of vx
    logic [1:0]  bcd_h;
    logic [6:0]  bcd_rem;
    logic [14:0] bcd_prod;
    logic [3:0]  bcd_t, bcd_o;
    logic [7:0]  bcd_byte;
    always_comb begin
        if (r_vx >= 8'd200)      bcd_h = 2'd2;
        else if (r_vx >= 8'd100) bcd_h = 2'd1;
        else                     bcd_h = 2'd0;
        bcd_rem  = 7'(r_vx - 8'(bcd_h) * 8'd100);
        bcd_prod = 15'(bcd_rem) * 15'd205;
        bcd_t    = bcd_prod[14:11];
        bcd_o    = 4'(bcd_rem - 7'(bcd_t) * 7'd10);
        case (r_cnt[1:0])
            2'd0:    bcd_byte = {6'd0, bcd_h};
            2'd1:    bcd_byte = {4'd0, bcd_t};
            default: bcd_byte = {4'd0, bcd_o};
        endcase
    end

    // sprite row geometry
    logic [5:0]  d_row;
    logic        d_stop;
    logic [63:0] d_bits;
    assign d_row  = {1'b0, r_vy[4:0]} + {1'b0, r_cnt};
    assign d_stop = (r_cnt == {1'b0, op_n}) || d_row[5];
    assign d_bits = {mem_rdata, 56'd0} >> r_vx[5:0];

    // alu for the 8XYN group
    logic [8:0] alu_sum;
    logic [7:0] alu_res, alu_flag;
    logic       alu_two, alu_bad;
    always_comb begin
        alu_sum  = {1'b0, r_vx} + {1'b0, reg_q};
        alu_res  = 8'd0;
        alu_flag = 8'd0;
        alu_two  = 1'b1;
        alu_bad  = 1'b0;
        case (op_n)
            ALU_MOV: begin alu_res = reg_q;        alu_two = 1'b0; end
            ALU_OR:  begin alu_res = r_vx | reg_q; alu_two = 1'b0; end
            ALU_AND: begin alu_res = r_vx & reg_q; alu_two = 1'b0; end
            ALU_XOR: begin alu_res = r_vx ^ reg_q; alu_two = 1'b0; end
            ALU_ADD: begin
                alu_res  = alu_sum[7:0];
                alu_flag = {7'd0, alu_sum[8]};
            end
            ALU_SUB: begin
                alu_res  = r_vx - reg_q;
                alu_flag = {7'd0, r_vx >= reg_q};
            end
            ALU_SHR: begin
                alu_res  = {1'b0, r_vx[7:1]};
                alu_flag = {7'd0, r_vx[0]};
            end
            ALU_SBN: begin
                alu_res  = reg_q - r_vx;
                alu_flag = {7'd0, reg_q >= r_vx};
            end
            ALU_SHL: begin
                alu_res  = {r_vx[6:0], 1'b0};
                alu_flag = {7'd0, r_vx[7]};
            end
            default: begin alu_two = 1'b0; alu_bad = 1'b1; end
        endcase
    end

    logic in_fire, out_fire, key_hit;
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = r_out_valid && i_out_ready;
    assign key_hit  = r_in.keys_down[r_vx[3:0]];

    // ram address and write control per state
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_i + 12'(r_cnt);
        mem_wdata = reg_q;
        mem_raddr = r_i + 12'(r_cnt);
        reg_we    = 1'b0;
        reg_waddr = op_x;
        reg_wdata = alu_res;
        reg_raddr = r_cnt[3:0];
        stk_we    = 1'b0;
        stk_waddr = r_sp;
        stk_wdata = r_pc;
        stk_raddr = r_sp - 4'd1;
        frm_we    = 1'b0;
        frm_waddr = d_row[4:0];
        frm_wdata = frm_q ^ d_bits;
        frm_raddr = d_row[4:0];
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = font_byte;
            end
            S_MWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_in.address;
                mem_wdata = r_in.data_byte;
            end
            S_ROW_RD: frm_raddr = r_in.address[4:0];
            S_F0:     mem_raddr = r_pc;
            S_F1: begin
                mem_raddr = r_pc + 12'd1;
                reg_raddr = mem_rdata[3:0];
            end
            S_F2: begin
                // BNNN needs V0 in place of VY
                reg_raddr = (r_op[15:12] == OP_JPV0) ? 4'd0 : mem_rdata[7:4];
            end
            S_EX: begin
                unique case (r_op[15:12])
                    OP_CALL: stk_we = 1'b1;
                    OP_LDI: begin
                        reg_we    = 1'b1;
                        reg_wdata = op_nn;
                    end
                    OP_ADDI: begin
                        reg_we    = 1'b1;
                        reg_wdata = r_vx + op_nn;
                    end
                    OP_RND: begin
                        reg_we    = 1'b1;
                        reg_wdata = r_in.random_byte & op_nn;
                    end
                    OP_ALU: reg_we = !alu_bad;
                    OP_MISC: begin
                        reg_we    = (op_nn == F_GDT);
                        reg_wdata = r_dt;
                    end
                    default: ;
                endcase
            end
            S_FLAG: begin
                reg_we    = 1'b1;
                reg_waddr = VF;
                reg_wdata = r_flag;
            end
            S_D_WR: frm_we = 1'b1;
            S_D_END: begin
                reg_we    = 1'b1;
                reg_waddr = VF;
                reg_wdata = {7'd0, r_hit};
            end
            S_BCD: begin
                mem_we    = 1'b1;
                mem_wdata = bcd_byte;
            end
            S_ST_WR: mem_we = 1'b1;
            S_LD_WR: begin
                reg_we    = 1'b1;
                reg_waddr = r_cnt[3:0];
                reg_wdata = mem_rdata;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (r_clr == 12'(MEMORY_BYTES - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in_data.mode)
                        MODE_LOAD: n_state = S_MWR;
                        MODE_EXEC: n_state = S_F0;
                        MODE_ROW:  n_state = S_ROW_RD;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_MWR:     n_state = S_DONE;
            S_ROW_RD:  n_state = S_ROW_CAP;
            S_ROW_CAP: n_state = S_DONE;
            S_F0:      n_state = S_F1;
            S_F1:      n_state = S_F2;
            S_F2:      n_state = S_EX;
            S_EX: begin
                n_state = S_TICK;
                unique case (r_op[15:12])
                    OP_ALU:  if (alu_two) n_state = S_FLAG;
                    OP_DRW:  n_state = S_D_RD;
                    OP_MISC: begin
                        if (op_nn == F_BCD)      n_state = S_BCD;
                        else if (op_nn == F_STR) n_state = S_ST_RD;
                        else if (op_nn == F_LDR) n_state = S_LD_RD;
                    end
                    default: ;
                endcase
            end
            S_FLAG:    n_state = S_TICK;
            S_D_RD:    n_state = d_stop ? S_D_END : S_D_WR;
            S_D_WR:    n_state = S_D_RD;
            S_D_END:   n_state = S_TICK;
            S_BCD:     if (r_cnt == 5'd2) n_state = S_TICK;
            S_ST_RD:   n_state = S_ST_WR;
            S_ST_WR:   n_state = (r_cnt[3:0] == op_x) ? S_TICK : S_ST_RD;
            S_LD_RD:   n_state = S_LD_WR;
            S_LD_WR:   n_state = (r_cnt[3:0] == op_x) ? S_TICK : S_LD_RD;
            S_TICK:    n_state = S_DONE;
            S_DONE:    if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= 12'd0;
            r_pc        <= PROGRAM_START;
            r_i         <= 12'd0;
            r_sp        <= 4'd0;
            r_dt        <= DELAY_RESET;
            r_st        <= 8'd0;
            r_reg_ok    <= '0;
            r_stk_ok    <= '0;
            r_frm_ok    <= '0;
            r_reg_rok   <= 1'b0;
            r_stk_rok   <= 1'b0;
            r_frm_rok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_reg_rok <= r_reg_ok[reg_raddr];
            r_stk_rok <= r_stk_ok[stk_raddr];
            r_frm_rok <= r_frm_ok[frm_raddr];
            if (reg_we) r_reg_ok[reg_waddr] <= 1'b1;
            if (stk_we) r_stk_ok[stk_waddr] <= 1'b1;
            if (frm_we) r_frm_ok[frm_waddr] <= 1'b1;
            if (r_state == S_CLEAR) r_clr <= r_clr + 12'd1;
            if (r_state == S_F2) r_pc <= r_pc + 12'd2;

            if (r_state == S_EX) begin
                unique case (r_op[15:12])
                    OP_SYS: begin
                        if (r_op == W_CLS) begin
                            r_frm_ok <= '0;
                        end else if (r_op == W_RET) begin
                            r_sp <= r_sp - 4'd1;
                            r_pc <= stk_q;
                        end
                    end
                    OP_JP: r_pc <= op_nnn;
                    OP_CALL: begin
                        r_sp <= r_sp + 4'd1;
                        r_pc <= op_nnn;
                    end
                    OP_SEI:  if (r_vx == op_nn) r_pc <= r_pc + 12'd2;
                    OP_SNEI: if (r_vx != op_nn) r_pc <= r_pc + 12'd2;
                    OP_SER:  if (r_vx == reg_q) r_pc <= r_pc + 12'd2;
                    OP_SNER: if (r_vx != reg_q) r_pc <= r_pc + 12'd2;
                    OP_LDIX: r_i <= op_nnn;
                    OP_JPV0: r_pc <= op_nnn + {4'd0, reg_q};
                    OP_KEY: begin
                        if ((op_nn == K_SKP && key_hit) || (op_nn == K_SKNP && !key_hit)) begin
                            r_pc <= r_pc + 12'd2;
                        end
                    end
                    OP_MISC: begin
                        case (op_nn)
                            F_SDT: r_dt <= r_vx;
                            F_SST: r_st <= r_vx;
                            F_ADI: r_i  <= r_i + {4'd0, r_vx};
                            F_FNT: r_i  <= FONT_START + {6'd0, r_vx[3:0], 2'd0}
                                           + {8'd0, r_vx[3:0]};
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end

            if (r_state == S_TICK) begin
                if (r_dt != 8'd0) r_dt <= r_dt - 8'd1;
                if (r_st != 8'd0) r_st <= r_st - 8'd1;
            end

            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and per-item working registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in      <= i_in_data;
            r_op      <= 16'd0;
            r_status  <= 1'b0;
            r_changed <= 1'b0;
            r_row     <= 64'd0;
        end
        case (r_state)
            S_ROW_CAP: r_row <= frm_q;
            S_F1:      r_op[15:8] <= mem_rdata;
            S_F2: begin
                r_op[7:0] <= mem_rdata;
                r_vx      <= reg_q;
            end
            S_EX: begin
                r_vy   <= reg_q;
                r_flag <= alu_flag;
                r_cnt  <= 5'd0;
                r_hit  <= 1'b0;
                unique case (r_op[15:12])
                    OP_SYS: begin
                        if (r_op == W_CLS)      r_changed <= 1'b1;
                        else if (r_op != W_RET) r_status  <= 1'b1;
                    end
                    OP_ALU: r_status <= alu_bad;
                    OP_DRW: r_changed <= 1'b1;
                    OP_KEY: r_status <= (op_nn != K_SKP) && (op_nn != K_SKNP);
                    OP_MISC: begin
                        case (op_nn) inside
                            F_GDT, F_SDT, F_SST, F_ADI, F_FNT, F_BCD, F_STR, F_LDR: ;
                            default: r_status <= 1'b1;
                        endcase
                    end
                    default: ;
                endcase
            end
            S_D_WR: begin
                r_hit <= r_hit | (|(frm_q & d_bits));
                r_cnt <= r_cnt + 5'd1;
            end
            S_BCD, S_ST_WR, S_LD_WR: r_cnt <= r_cnt + 5'd1;
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out.status          <= r_status;
                    r_out.program_counter <= r_pc;
                    r_out.executed_opcode <= r_op;
                    r_out.display_changed <= r_changed;
                    r_out.sound_active    <= (r_st != 8'd0);
                    r_out.row_pixels      <= r_row;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/c8x_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/c8x_checker.sv =====
// port-level checker for the chip8 execute unit, bound to the top level
// depends on c8x_pkg and assert_macros.svh
`include "assert_macros.svh"

module c8x_checker
    import c8x_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // a stalled result beat holds
    `C8X_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // a row read never carries an instruction word
    `C8X_ASSERT_IMP(a_row_no_op, i_clk, i_rst_n, o_out_valid && (o_out_data.row_pixels != 64'd0), o_out_data.executed_opcode == 16'd0)

    // an unknown instruction never touches the display
    `C8X_ASSERT_IMP(a_bad_quiet, i_clk, i_rst_n, o_out_valid && o_out_data.status, !o_out_data.display_changed)

    // only clear screen or sprite draw report a display change
    `C8X_ASSERT_IMP(a_chg_src, i_clk, i_rst_n, o_out_valid && o_out_data.display_changed, (o_out_data.executed_opcode == 16'h00E0) || (o_out_data.executed_opcode[15:12] == 4'hD))

endmodule

bind chip8_instruction_execute_unit c8x_checker u_c8x_checker (.*);
